[rtl/deoq_pkg.sv]
`default_nettype none
package deoq_pkg;

  // Default number of queue entries.
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  // Field widths.
  localparam int SEC_W  = 32;
  localparam int NSEC_W = 30;
  localparam int KEY_W  = SEC_W + NSEC_W;
  localparam int HDL_W  = 8;
  localparam int STAT_W = 3;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POLL   = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FIRED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_DUE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

  // One stored event: deadline key {sec, nsec} and its handler id.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] handler;
  } entry_t;

endpackage
`default_nettype wire

[rtl/deoq_mem.sv]
`default_nettype none
module deoq_mem #(
  parameter int QUEUE_DEPTH = deoq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] waddr,
  input  wire deoq_pkg::entry_t               wdata,
  input  wire logic                           re,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] raddr,
  output deoq_pkg::entry_t                    rdata
);
  import deoq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/deoq_cmp.sv]
`default_nettype none
module deoq_cmp (
  input  wire logic [deoq_pkg::KEY_W-1:0] a,
  input  wire logic [deoq_pkg::KEY_W-1:0] b,
  output logic                            a_gt_b
);
  import deoq_pkg::*;

  // Shared magnitude compare used by both the insert walk and the poll check.
  assign a_gt_b = (a > b);

endmodule
`default_nettype wire

[rtl/deoq_seq.sv]
`default_nettype none
module deoq_seq #(
  parameter int QUEUE_DEPTH = deoq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           cmd,
  input  wire logic [deoq_pkg::SEC_W-1:0]     deadline_sec,
  input  wire logic [deoq_pkg::NSEC_W-1:0]    deadline_nsec,
  input  wire logic [deoq_pkg::HDL_W-1:0]     handler_in,
  input  wire logic [deoq_pkg::SEC_W-1:0]     now_sec,
  output logic                                done,
  output logic [deoq_pkg::STAT_W-1:0]         status,
  output logic [deoq_pkg::HDL_W-1:0]          handler_out,
  // Memory port.
  output logic                                mem_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      mem_waddr,
  output deoq_pkg::entry_t                    mem_wdata,
  output logic                                mem_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      mem_raddr,
  input  wire deoq_pkg::entry_t               mem_rdata,
  // Shared compare unit.
  output logic [deoq_pkg::KEY_W-1:0]          cmp_b,
  input  wire logic                           cmp_gt
);
  import deoq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_STEP = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_POLL_CMP = 3'd3;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [KEY_W-1:0] key, key_next;
  logic [HDL_W-1:0] hdl, hdl_next;
  logic             done_next;
  logic [STAT_W-1:0] status_next;
  logic [HDL_W-1:0] handler_out_next;

  logic [CNT_W-1:0] idx_dec;
  logic [SUM_W-1:0] rd_sum, wr_sum;
  logic [PTR_W-1:0] phys_rd, phys_wr;
  logic             full, empty;

  // Logical to physical address mapping over the circular buffer.
  assign idx_dec = idx - CNT_W'(1);
  always_comb begin
    rd_sum = SUM_W'(head) + SUM_W'(idx_dec);
    if (rd_sum >= SUM_W'(QUEUE_DEPTH)) begin
      rd_sum = rd_sum - SUM_W'(QUEUE_DEPTH);
    end
    wr_sum = SUM_W'(head) + SUM_W'(idx);
    if (wr_sum >= SUM_W'(QUEUE_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(QUEUE_DEPTH);
    end
  end
  assign phys_rd = rd_sum[PTR_W-1:0];
  assign phys_wr = wr_sum[PTR_W-1:0];

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign busy  = (state != S_IDLE);
  assign cmp_b = key;

  // Sequencer: insert walks from the tail toward the head, one entry at a time; poll checks the head.
  always_comb begin
    state_next       = state;
    count_next       = count;
    head_next        = head;
    idx_next         = idx;
    key_next         = key;
    hdl_next         = hdl;
    done_next        = 1'b0;
    status_next      = status;
    handler_out_next = handler_out;
    mem_we           = 1'b0;
    mem_waddr        = phys_wr;
    mem_wdata        = '{key: key, handler: hdl};
    mem_re           = 1'b0;
    mem_raddr        = phys_rd;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd == CMD_INSERT) begin
            key_next = {deadline_sec, deadline_nsec};
            hdl_next = handler_in;
            idx_next = count;
            if (full) begin
              done_next        = 1'b1;
              status_next      = ST_FULL;
              handler_out_next = '0;
            end else begin
              state_next = S_INS_STEP;
            end
          end else begin
            // A head is not due when its key exceeds {now, all-ones nsec}.
            key_next = {now_sec, {NSEC_W{1'b1}}};
            if (empty) begin
              done_next        = 1'b1;
              status_next      = ST_EMPTY;
              handler_out_next = '0;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = head;
              state_next = S_POLL_CMP;
            end
          end
        end
      end
      S_INS_STEP: begin
        if (idx == '0) begin
          mem_we           = 1'b1;
          count_next       = count + CNT_W'(1);
          done_next        = 1'b1;
          status_next      = ST_INSERTED;
          handler_out_next = '0;
          state_next       = S_IDLE;
        end else begin
          mem_re     = 1'b1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (cmp_gt) begin
          // Stored entry is later: move it one place toward the tail.
          mem_wdata  = mem_rdata;
          idx_next   = idx_dec;
          state_next = S_INS_STEP;
        end else begin
          count_next       = count + CNT_W'(1);
          done_next        = 1'b1;
          status_next      = ST_INSERTED;
          handler_out_next = '0;
          state_next       = S_IDLE;
        end
      end
      S_POLL_CMP: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (cmp_gt) begin
          status_next      = ST_NOT_DUE;
          handler_out_next = '0;
        end else begin
          status_next      = ST_FIRED;
          handler_out_next = mem_rdata.handler;
          count_next       = count - CNT_W'(1);
          head_next        = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      done  <= done_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    key         <= key_next;
    hdl         <= hdl_next;
    status      <= status_next;
    handler_out <= handler_out_next;
  end

endmodule
`default_nettype wire

[rtl/deadline_ordered_event_queue_core.sv]
`default_nettype none
// Deadline-ordered event queue.
//
// Command channel: a word is taken at a rising edge where start is high and
// busy is low. cmd selects insert (deadline_sec, deadline_nsec, handler_in)
// or poll (now_sec). Every command gives exactly one result word: status and
// handler_out, shown for one cycle while done is high.
//
// Results: a refused insert (queue full) or a poll of an empty queue answers
// in the cycle after the command. A poll reads the head entry and answers from
// S_POLL_CMP. An insert walks from the tail: each stored entry with a later
// deadline is read in S_INS_STEP, then compared and moved one place through
// the entry memory in S_INS_CMP, compared by one shared comparator; the walk
// ends at an entry that is not later or at the head. busy stays high until the
// result is shown, so the next command can be taken in the cycle where done
// is high.
//
// Reset empties the queue at once; no memory clearing is needed. The receiver
// cannot stall: done is a strobe and the result is lost if not captured.
module deadline_ordered_event_queue_core #(
  parameter int QUEUE_DEPTH = deoq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        cmd,
  input  wire logic [deoq_pkg::SEC_W-1:0]  deadline_sec,
  input  wire logic [deoq_pkg::NSEC_W-1:0] deadline_nsec,
  input  wire logic [deoq_pkg::HDL_W-1:0]  handler_in,
  input  wire logic [deoq_pkg::SEC_W-1:0]  now_sec,
  output logic                             done,
  output logic [deoq_pkg::STAT_W-1:0]      status,
  output logic [deoq_pkg::HDL_W-1:0]       handler_out
);
  import deoq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;
  logic [KEY_W-1:0] cmp_b;
  logic             cmp_gt;

  // Command sequencer.
  deoq_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .deadline_sec (deadline_sec),
    .deadline_nsec(deadline_nsec),
    .handler_in   (handler_in),
    .now_sec      (now_sec),
    .done         (done),
    .status       (status),
    .handler_out  (handler_out),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .cmp_b        (cmp_b),
    .cmp_gt       (cmp_gt)
  );

  // Entry storage, kept as a circular buffer.
  deoq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Shared deadline comparator.
  deoq_cmp u_cmp (
    .a     (mem_rdata.key),
    .b     (cmp_b),
    .a_gt_b(cmp_gt)
  );

endmodule
`default_nettype wire

[sim/deadline_ordered_event_queue_core_tb.sv]
`default_nettype none
module deadline_ordered_event_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deoq_pkg::*;

  localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
  // The tail wait covers the longest insert with margin.
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;
  localparam int STALL_LIMIT = 1000;
  localparam logic [NSEC_W-1:0] NSEC_MAX_LEGAL = NSEC_W'(999_999_999);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HDL_W-1:0]  handler;
  } result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              cmd = CMD_INSERT;
  logic [SEC_W-1:0]  deadline_sec = '0;
  logic [NSEC_W-1:0] deadline_nsec = '0;
  logic [HDL_W-1:0]  handler_in = '0;
  logic [SEC_W-1:0]  now_sec = '0;
  logic              busy;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [HDL_W-1:0]  handler_out;

  // Local copy of the sorted schedule: deadline keys and their handler ids.
  logic [KEY_W-1:0] sched_key[$];
  logic [HDL_W-1:0] sched_hdl[$];
  result_t          expected_results[$];

  int mismatch_count = 0;
  int stall_cycles = 0;
  int status_tally[5] = '{default: 0};
  int idle_pct = 0;
  logic [SEC_W-1:0] window_base = '0;

  deadline_ordered_event_queue_core #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .deadline_sec(deadline_sec),
    .deadline_nsec(deadline_nsec),
    .handler_in(handler_in),
    .now_sec(now_sec),
    .done(done),
    .status(status),
    .handler_out(handler_out)
  );

  always #5 clk = ~clk;

  // Apply one command word to the local schedule and return the result it gives.
  function automatic result_t apply_command(logic c, logic [SEC_W-1:0] s,
                                            logic [NSEC_W-1:0] ns, logic [HDL_W-1:0] h,
                                            logic [SEC_W-1:0] now);
    result_t r;
    int pos;
    logic [KEY_W-1:0] key;
    r.handler = '0;
    key = {s, ns};
    if (c == CMD_INSERT) begin
      if (sched_key.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // Equal deadlines go behind the ones already stored.
        pos = 0;
        while (pos < sched_key.size() && sched_key[pos] <= key) pos++;
        sched_key.insert(pos, key);
        sched_hdl.insert(pos, h);
        r.status = ST_INSERTED;
      end
    end else if (sched_key.size() == 0) begin
      r.status = ST_EMPTY;
    end else if (now < sched_key[0][KEY_W-1:NSEC_W]) begin
      r.status = ST_NOT_DUE;
    end else begin
      r.status = ST_FIRED;
      r.handler = sched_hdl.pop_front();
      void'(sched_key.pop_front());
    end
    return r;
  endfunction

  // Check each result word against the oldest expectation, then record the
  // expectation of a command word taken at this edge.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: status %0d handler_out %0d", status, handler_out);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatch_count++;
          end
          if (handler_out !== want.handler) begin
            $error("handler_out: expected %0d, actual %0d", want.handler, handler_out);
            mismatch_count++;
          end
          if (want.status <= ST_EMPTY) status_tally[want.status]++;
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_command(cmd, deadline_sec, deadline_nsec,
                                                 handler_in, now_sec));
      end
    end
  end

  // Watchdog: too many cycles without any word moving ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("deadline_ordered_event_queue_core_tb: errors");
      $finish;
    end
  end

  // Present one command word and wait until it is taken; then maybe go idle.
  task automatic send_word(logic c, logic [SEC_W-1:0] s, logic [NSEC_W-1:0] ns,
                           logic [HDL_W-1:0] h, logic [SEC_W-1:0] now);
    start <= 1'b1;
    cmd <= c;
    deadline_sec <= s;
    deadline_nsec <= ns;
    handler_in <= h;
    now_sec <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result word has come back.
  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Polls of an empty queue at both ends of the time range.
  task automatic test_empty_polls();
    send_word(CMD_POLL, '0, '0, '0, '0);
    send_word(CMD_POLL, '1, '1, '1, '1);
  endtask

  // A head is due exactly when now reaches its seconds; one second early it is not.
  task automatic test_due_boundary();
    send_word(CMD_INSERT, 32'd100, NSEC_MAX_LEGAL, 8'h5a, '1);
    send_word(CMD_POLL, '0, '0, '0, 32'd99);
    send_word(CMD_POLL, '1, '1, '1, 32'd100);
  endtask

  // Fill the queue with extreme and tied deadlines, overflow it, then fire twice.
  task automatic test_fill_and_overflow();
    logic [SEC_W-1:0] s;
    logic [NSEC_W-1:0] ns;
    logic [HDL_W-1:0] h;
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: s = '1;
        1: s = '0;
        default: s = 32'd5;
      endcase
      case (i % 3)
        0: ns = '0;
        1: ns = NSEC_MAX_LEGAL;
        default: ns = '1;
      endcase
      h = (i == 0) ? 8'h00 : (i == DEPTH - 1) ? 8'hff : HDL_W'(i * 17);
      send_word(CMD_INSERT, s, ns, h, '0);
    end
    send_word(CMD_INSERT, 32'd1, '0, 8'haa, '0);
    send_word(CMD_POLL, '0, '0, '0, '0);
    send_word(CMD_POLL, '0, '0, '0, '1);
  endtask

  // One random command word; most deadlines and times fall in a narrow window
  // so that ties, due heads and late heads all occur.
  task automatic send_random(int insert_pct);
    logic [SEC_W-1:0] s;
    logic [SEC_W-1:0] now;
    logic [NSEC_W-1:0] ns;
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) s = window_base + $urandom_range(0, 15);
    else if (pick < 90) s = $urandom;
    else s = $urandom_range(1) ? '1 : '0;
    pick = $urandom_range(99);
    if (pick < 50) ns = NSEC_W'($urandom_range(0, 3));
    else if (pick < 90) ns = NSEC_W'($urandom_range(0, 999_999_999));
    else ns = NSEC_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 70) now = window_base + $urandom_range(0, 15);
    else if (pick < 90) now = $urandom;
    else now = $urandom_range(1) ? '1 : '0;
    send_word(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_POLL, s, ns,
              HDL_W'($urandom_range(0, 255)), now);
  endtask

  // Bursts that lean toward filling, mixing or emptying the queue.
  task automatic test_random_traffic(int count, int pct);
    int sent;
    int burst_len;
    int insert_pct;
    idle_pct = pct;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(4))
        0: window_base = '0;
        1: window_base = 32'hffff_fff0;
        default: window_base = $urandom_range(0, 32'hffff_fff0);
      endcase
      case ($urandom_range(2))
        0: insert_pct = 85;
        1: insert_pct = 50;
        default: insert_pct = 20;
      endcase
      burst_len = $urandom_range(10, 40);
      repeat (burst_len) begin
        send_random(insert_pct);
        sent++;
      end
      if ($urandom_range(9) == 0) wait_until_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 0;
    test_empty_polls();
    test_due_boundary();
    test_fill_and_overflow();
    wait_until_drained();

    test_random_traffic(240, 0);
    wait_until_drained();
    test_random_traffic(230, 52);
    wait_until_drained();
    test_random_traffic(230, 27);
    wait_until_drained();
    test_random_traffic(230, 0);

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered: %0d inserted, %0d refused on full, %0d fired, %0d not due, %0d empty",
             status_tally[ST_INSERTED], status_tally[ST_FULL], status_tally[ST_FIRED],
             status_tally[ST_NOT_DUE], status_tally[ST_EMPTY]);
    $display("mismatches found: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("deadline_ordered_event_queue_core_tb: clean");
    end else begin
      $display("deadline_ordered_event_queue_core_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

[deadline_ordered_event_queue_core.f]
rtl/deoq_pkg.sv
rtl/deoq_mem.sv
rtl/deoq_cmp.sv
rtl/deoq_seq.sv
rtl/deadline_ordered_event_queue_core.sv
sim/deadline_ordered_event_queue_core_tb.sv
